FILE: rtl/core/stlfo_pkg.sv
package stlfo_pkg;

  localparam int PHASE_W = 32;
  localparam int CFG_W   = 32;
  localparam int DEPTH_W = 17;
  localparam int TAB_W   = 17;
  localparam int GAIN_W  = 33;
  localparam int DP_W    = DEPTH_W + TAB_W;

  // unity gain in Q32
  localparam logic [DP_W-1:0] GAIN_ONE = DP_W'(64'd1 << 32);

  // angles in Q30
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef enum logic {
    REG_PHASE_STEP,
    REG_DEPTH
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_GAIN,
    ST_MUL,
    ST_SAT
  } state_t;

  typedef struct packed {
    logic gain_en;
    logic mul_en;
  } dp_ctl_t;

  // first-quadrant sine in Q30, taylor series to x^13, evaluated at elaboration
  function automatic longint unsigned quarter_sine(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    return longint'(sum);
  endfunction

  // table entry 0.5 + 0.5*sin in Q0.16 for a full-turn angle in Q30
  function automatic logic [TAB_W-1:0] lfo_entry(longint unsigned angle);
    longint unsigned x;
    longint unsigned m;
    longint unsigned u;
    logic neg;
    x   = angle;
    neg = 1'b0;
    if (x >= PI_Q30) begin
      x   = x - PI_Q30;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q30) begin
      x = PI_Q30 - x;
    end
    m = quarter_sine(x);
    if (neg) begin
      u = (ONE_Q30 - m + (64'd1 << 14)) >> 15;
    end else begin
      u = (ONE_Q30 + m + (64'd1 << 14)) >> 15;
    end
    return TAB_W'(u);
  endfunction

endpackage

FILE: rtl/core/stlfo_if.sv
interface stlfo_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface stlfo_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

FILE: rtl/core/sine_lfo_tremolo_core.sv
// Sine LFO tremolo. Each word on din advances a 32-bit phase accumulator by
// phase_step, picks the entry of a SINE_TABLE_DEPTH-entry sine table chosen by
// the new phase times SINE_TABLE_DEPTH over 2^32, and scales the sample by
// 1 - depth*(0.5+0.5*sin), truncating toward zero and clamping to the sample
// range. One result word per input word, in order. A word passes the table
// read, the gain multiply, the sample multiply and the clamp in turn, on a
// single shared path that holds one word at a time; the clamp waits while the
// output register is full. The output register lets the next word in while a
// result waits on dout. The table is a constant rom built at elaboration with
// a registered read, so there is no fill after reset. Write phase_step (index
// 0) and depth (index 1, Q0.16, 65536 is full depth) only while the block is
// idle.
module sine_lfo_tremolo_core
  import stlfo_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH     = 24
) (
  input  logic             clk,
  input  logic             rst,
  stlfo_in_if.sink         din,
  stlfo_out_if.source      dout,
  input  logic             write_enable,
  input  reg_index_t       reg_index,
  input  logic [CFG_W-1:0] write_data
);

  localparam int IdxW   = $clog2(SINE_TABLE_DEPTH);
  localparam int ScaleW = PHASE_W + $clog2(SINE_TABLE_DEPTH + 1);

  state_t                         state;
  state_t                         state_next;
  logic [PHASE_W-1:0]             phase;
  logic [PHASE_W-1:0]             phase_step;
  logic [DEPTH_W-1:0]             depth;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_data;
  logic                           accept;
  logic                           out_free;
  logic                           out_load;
  dp_ctl_t                        ctl;
  logic [ScaleW-1:0]              phase_scaled;
  logic [IdxW-1:0]                lfo_idx;
  logic [TAB_W-1:0]               lfo_u;
  logic signed [SAMPLE_WIDTH-1:0] result;

  assign accept   = din.valid && din.ready;
  assign out_free = !out_valid || dout.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (din.valid) begin
          state_next = ST_INDEX;
        end
      end
      ST_INDEX: state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_SAT;
      ST_SAT: begin
        if (out_free) begin
          state_next = din.valid ? ST_INDEX : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    din.ready   = (state == ST_IDLE) || ((state == ST_SAT) && out_free);
    ctl.gain_en = state == ST_GAIN;
    ctl.mul_en  = state == ST_MUL;
    out_load    = (state == ST_SAT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= '0;
      phase_step <= '0;
      depth      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (write_enable) begin
        unique case (reg_index)
          REG_PHASE_STEP: phase_step <= write_data[PHASE_W-1:0];
          REG_DEPTH:      depth      <= write_data[DEPTH_W-1:0];
          default:        ;
        endcase
      end
      if (accept) begin
        phase <= phase + phase_step;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= din.sample_in;
    end
    if (out_load) begin
      out_data <= result;
    end
  end

  // table index is phase * depth / 2^32
  assign phase_scaled = ScaleW'(phase) * ScaleW'(SINE_TABLE_DEPTH);
  assign lfo_idx      = phase_scaled[PHASE_W +: IdxW];

  stlfo_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (lfo_idx),
    .q    (lfo_u)
  );

  stlfo_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .ctl    (ctl),
    .sample (sample_r),
    .depth  (depth),
    .lfo_u  (lfo_u),
    .result (result)
  );

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_INDEX)
    else $error("accepted word did not start the table read");

  a_phase_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase))
    else $error("phase moved without an accepted word");

  a_result_from_clamp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_SAT)
    else $error("result word appeared outside the clamp step");
`endif

endmodule

FILE: rtl/core/stlfo_sine_rom.sv
module stlfo_sine_rom
  import stlfo_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int IdxW = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic [IdxW-1:0]  addr,
  output logic [TAB_W-1:0] q
);

  logic [TAB_W-1:0] rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
    // angle of entry k in Q30, rounded to nearest
    localparam longint unsigned Angle =
      (2 * PI_Q30 * longint'(k) + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
    assign rom[k] = lfo_entry(Angle);
  end

  always_ff @(posedge clk) begin
    q <= rom[addr];
  end

endmodule

FILE: rtl/core/stlfo_datapath.sv
module stlfo_datapath
  import stlfo_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  dp_ctl_t                        ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic [DEPTH_W-1:0]             depth,
  input  logic [TAB_W-1:0]               lfo_u,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  localparam int FullW = SAMPLE_WIDTH + GAIN_W;
  localparam logic [SAMPLE_WIDTH:0] PosMax = {2'b00, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH:0] NegLim = {2'b01, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [DP_W-1:0]         dp;
  logic                    gneg_next;
  logic [GAIN_W-1:0]       gmag_next;
  logic [SAMPLE_WIDTH-1:0] smag_next;
  logic                    gneg;
  logic [GAIN_W-1:0]       gmag;
  logic                    sneg;
  logic [SAMPLE_WIDTH-1:0] smag;
  logic [FullW-1:0]        full;
  logic [SAMPLE_WIDTH:0]   prod;
  logic                    neg;
  logic [SAMPLE_WIDTH:0]   prod_neg;

  // gain = 1 - depth*u in Q32, split into sign and magnitude
  assign dp        = DP_W'(depth) * DP_W'(lfo_u);
  assign gneg_next = dp > GAIN_ONE;
  assign gmag_next = gneg_next ? GAIN_W'(dp - GAIN_ONE) : GAIN_W'(GAIN_ONE - dp);
  assign smag_next = sample[SAMPLE_WIDTH-1] ? $unsigned(-sample) : $unsigned(sample);

  assign full = FullW'(smag) * FullW'(gmag);

  always_ff @(posedge clk) begin
    if (ctl.gain_en) begin
      gneg <= gneg_next;
      gmag <= gmag_next;
      sneg <= sample[SAMPLE_WIDTH-1];
      smag <= smag_next;
    end
    if (ctl.mul_en) begin
      prod <= full[FullW-1:32];
      neg  <= sneg ^ gneg;
    end
  end

  assign prod_neg = -prod;

  // truncation toward zero is already in the magnitude; clamp to range
  always_comb begin
    priority if (neg && (prod > NegLim)) begin
      result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else if (neg) begin
      result = prod_neg[SAMPLE_WIDTH-1:0];
    end else if (prod > PosMax) begin
      result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      result = prod[SAMPLE_WIDTH-1:0];
    end
  end

endmodule
